// ===== rtl/core/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 byte stream decoder.
package u8dec_pkg;

    // Field widths.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 16;
    localparam int unsigned ST_W   = 2;

    // Result status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FOUR    = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // Lead byte class masks and patterns.
    localparam logic [BYTE_W-1:0] MASK_ONE   = 8'b1000_0000;
    localparam logic [BYTE_W-1:0] PAT_ONE    = 8'b0000_0000;
    localparam logic [BYTE_W-1:0] MASK_TWO   = 8'b1110_0000;
    localparam logic [BYTE_W-1:0] PAT_TWO    = 8'b1100_0000;
    localparam logic [BYTE_W-1:0] MASK_THREE = 8'b1111_0000;
    localparam logic [BYTE_W-1:0] PAT_THREE  = 8'b1110_0000;
    localparam logic [BYTE_W-1:0] MASK_FOUR  = 8'b1111_1000;
    localparam logic [BYTE_W-1:0] PAT_FOUR   = 8'b1111_0000;

    // Payload masks for lead and continuation bytes.
    localparam logic [BYTE_W-1:0] PAY_TWO   = 8'h1F;
    localparam logic [BYTE_W-1:0] PAY_THREE = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY_FOUR  = 8'h07;
    localparam logic [BYTE_W-1:0] PAY_CONT  = 8'h3F;

    // Sequence lengths.
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // One input request held in the input register.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
    } in_item_t;

    // One decode result between the core and the output register.
    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            string_end;
    } result_t;

endpackage

// ===== rtl/core/u8dec_in_reg.sv =====
// Input register stage: holds one accepted byte until the core takes it.
module u8dec_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  u8dec_pkg::in_item_t  s_item,
    input  logic                 advance,
    output logic                 item_valid,
    output u8dec_pkg::in_item_t  item
);
    import u8dec_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register may load when empty or when its item moves on this cycle.
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads without reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/u8dec_core.sv =====
// Decoder state and the per-byte decode logic.
module u8dec_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  u8dec_pkg::in_item_t  item,
    output u8dec_pkg::result_t   result
);
    import u8dec_pkg::*;

    logic [1:0]      remain_reg;
    logic [1:0]      remain_next;
    logic [2:0]      seq_len_reg;
    logic [2:0]      seq_len_next;
    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic            skip_reg;
    logic            skip_next;

    logic [BYTE_W-1:0] b;
    logic              eos;
    logic [1:0]        remain_dec;
    logic [CP_W-1:0]   partial_shift;

    assign b             = item.data_byte;
    assign eos           = item.end_of_string;
    assign remain_dec    = remain_reg - 2'd1;
    assign partial_shift = {partial_reg[CP_W-7:0], b[5:0] & PAY_CONT[5:0]};

    // Decode one byte against the current sequence state.
    always_comb
    begin
        remain_next       = remain_reg;
        seq_len_next      = seq_len_reg;
        partial_next      = partial_reg;
        skip_next         = skip_reg;
        result.valid      = 1'b0;
        result.code_point = '0;
        result.status     = ST_OK;
        result.string_end = eos;

        if (skip_reg)
        begin
            // Dropping bytes until the string ends.
            if (eos)
            begin
                skip_next = 1'b0;
            end
        end
        else if (remain_reg == 2'd0)
        begin
            priority if ((b & MASK_ONE) == PAT_ONE)
            begin
                result.valid      = 1'b1;
                result.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
            end
            else if ((b & MASK_TWO) == PAT_TWO)
            begin
                partial_next = {{(CP_W-BYTE_W){1'b0}}, b & PAY_TWO};
                seq_len_next = LEN_TWO;
                remain_next  = 2'd1;
            end
            else if ((b & MASK_THREE) == PAT_THREE)
            begin
                partial_next = {{(CP_W-BYTE_W){1'b0}}, b & PAY_THREE};
                seq_len_next = LEN_THREE;
                remain_next  = 2'd2;
            end
            else if ((b & MASK_FOUR) == PAT_FOUR)
            begin
                partial_next = {{(CP_W-BYTE_W){1'b0}}, b & PAY_FOUR};
                seq_len_next = LEN_FOUR;
                remain_next  = 2'd3;
            end
            else
            begin
                // Continuation byte or out-of-range lead byte.
                skip_next     = !eos;
                result.valid  = 1'b1;
                result.status = ST_INVALID;
            end

            // A multi-byte lead on the last byte is a cut-off sequence.
            if (remain_next != 2'd0 && eos)
            begin
                remain_next       = 2'd0;
                seq_len_next      = LEN_NONE;
                partial_next      = '0;
                result.valid      = 1'b1;
                result.status     = ST_TRUNC;
                result.string_end = 1'b1;
            end
        end
        else
        begin
            // Continuation byte: shift in six payload bits.
            partial_next = partial_shift;
            remain_next  = remain_dec;
            if (remain_dec == 2'd0)
            begin
                result.valid = 1'b1;
                if (seq_len_reg == LEN_FOUR)
                begin
                    result.status = ST_FOUR;
                end
                else
                begin
                    result.code_point = partial_shift;
                end
                seq_len_next = LEN_NONE;
                partial_next = '0;
            end
            else if (eos)
            begin
                remain_next       = 2'd0;
                seq_len_next      = LEN_NONE;
                partial_next      = '0;
                result.valid      = 1'b1;
                result.status     = ST_TRUNC;
                result.string_end = 1'b1;
            end
        end

        // Single-byte results, invalid leads and finished sequences leave the sequence clear.
        if (remain_next == 2'd0)
        begin
            seq_len_next = LEN_NONE;
            partial_next = '0;
        end
    end

    // State updates only when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg  <= 2'd0;
            seq_len_reg <= LEN_NONE;
            partial_reg <= '0;
            skip_reg    <= 1'b0;
        end
        else if (fire)
        begin
            remain_reg  <= remain_next;
            seq_len_reg <= seq_len_next;
            partial_reg <= partial_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

// ===== rtl/core/u8dec_out_reg.sv =====
// Output register: holds one result until the receiver takes it.
module u8dec_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  u8dec_pkg::result_t  result,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         code_point,
    output logic [1:0]          status,
    output logic                string_end
);
    import u8dec_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [CP_W-1:0] cp_reg;
    status_t         st_reg;
    logic            end_reg;

    // A load replaces the held result; otherwise a taken result clears.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = result.valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.valid)
        begin
            cp_reg  <= result.code_point;
            st_reg  <= result.status;
            end_reg <= result.string_end;
        end
    end

    assign m_tvalid   = valid_reg;
    assign code_point = cp_reg;
    assign status     = st_reg;
    assign string_end = end_reg;

endmodule

// ===== rtl/core/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder.
//
// Bytes of a UTF-8 string arrive on the s_ channel, one request per byte,
// with s_tlast marking the last byte of each string. Results leave on the
// m_ channel: m_tdata carries the 16-bit code point, m_tuser the status
// (ok, four-byte unsupported, truncated, invalid lead) and m_tlast marks
// the result that ends a string. Not every byte yields a result: lead and
// middle bytes of a sequence and bytes dropped after an invalid lead are
// consumed silently.
// Throughput is one byte per cycle while the receiver keeps m_tready high.
// A byte is held in the input register, decoded by the state logic and
// registered in the output register, whose result then shows on
// m_tvalid. The rate is set by the single sequence-state update
// per byte.
// When the receiver stalls, the output register holds its result and the
// input register holds one more byte; s_tready then drops.
// Reset clears both registers and the sequence state; the block is ready
// for a new string right after reset.
module utf8_byte_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_point
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import u8dec_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     fire;
    result_t  result;

    assign s_item.data_byte     = s_tdata;
    assign s_item.end_of_string = s_tlast;

    // A byte is decoded when held and the output register can take a result.
    assign out_free = !m_tvalid || m_tready;
    assign fire     = item_valid && out_free;

    u8dec_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    u8dec_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    u8dec_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .code_point (m_tdata),
        .status     (m_tuser),
        .string_end (m_tlast)
    );

endmodule
